// File: hw/rtl/klfc_pkg.sv
// klfc_pkg: shared constants, key map and command types of the key LED fade controller
// no dependencies; used by the interfaces and by every module of the block

package klfc_pkg;

   localparam int NUM_LEDS   = 17;
   localparam int LED_IDX_W  = $clog2(NUM_LEDS);
   localparam int CSR_IDX_W  = 2;

   localparam logic [2:0] KIND_KEY    = 3'd0;
   localparam logic [2:0] KIND_TICK   = 3'd1;
   localparam logic [2:0] KIND_ENABLE = 3'd2;
   localparam logic [2:0] KIND_SLEEP  = 3'd3;
   localparam logic [2:0] KIND_WAKE   = 3'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_THEME_RED   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_THEME_GREEN = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_THEME_BLUE  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FADE_STEP   = 2'd3;

   localparam logic [7:0] NO_LED      = 8'hFF;
   localparam logic [7:0] FULL_BRIGHT = 8'd255;

   typedef enum logic [1:0] {
      CMD_KEY,
      CMD_TICK,
      CMD_CLEAR
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type           op;
      logic [LED_IDX_W-1:0] led;
      logic                 supply;
      logic                 stop_fade;
   } cmd_type;

   typedef logic [7:0] key_row_type [0:3];
   localparam key_row_type KEY_MAP [0:7] = '{
      '{NO_LED, NO_LED, NO_LED, NO_LED},
      '{8'd0,   8'd1,   8'd2,   8'd3},
      '{8'd4,   8'd5,   8'd6,   NO_LED},
      '{8'd7,   8'd8,   8'd9,   8'd10},
      '{8'd11,  8'd12,  8'd13,  NO_LED},
      '{8'd14,  8'd15,  NO_LED, 8'd16},
      '{NO_LED, NO_LED, NO_LED, NO_LED},
      '{NO_LED, NO_LED, NO_LED, NO_LED}
   };

   // led number for a matrix position, NO_LED where nothing is wired
   function automatic logic [7:0] key_to_led(input logic [2:0] row, input logic [2:0] col);
      logic [7:0] led;
      led = NO_LED;
      if (col[2] == 1'b0) begin
         led = KEY_MAP[row][col[1:0]];
      end
      if (led >= 8'(NUM_LEDS)) begin
         led = NO_LED;
      end
      return led;
   endfunction

   // c * b / 255 for 8-bit operands, exact over the full product range
   function automatic logic [7:0] scale(input logic [7:0] c, input logic [7:0] b);
      logic [15:0] prod;
      logic [16:0] sum;
      prod = 16'(c) * 16'(b);
      sum  = 17'(prod) + 17'(prod[15:8]) + 17'd1;
      return sum[15:8];
   endfunction

endpackage

// File: hw/rtl/klfc_if.sv
// klfc_if: valid/ready channel interfaces for request, response and csr words
// depends on klfc_pkg

interface klfc_req_if import klfc_pkg::*; ();
   logic       valid;
   logic       ready;
   logic [2:0] kind;
   logic       key_pressed;
   logic [2:0] key_row;
   logic [2:0] key_col;
   logic       enable_value;

   modport source (output valid, kind, key_pressed, key_row, key_col, enable_value,
                   input ready);
   modport sink   (input valid, kind, key_pressed, key_row, key_col, enable_value,
                   output ready);
endinterface

interface klfc_rsp_if import klfc_pkg::*; ();
   logic       valid;
   logic       ready;
   logic [4:0] led_index;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;
   logic       last_pixel;
   logic       power_on;

   modport source (output valid, led_index, red, green, blue, last_pixel, power_on,
                   input ready);
   modport sink   (input valid, led_index, red, green, blue, last_pixel, power_on,
                   output ready);
endinterface

interface klfc_csr_if import klfc_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [7:0]           data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// File: hw/rtl/klfc_front.sv
// klfc_front: accepts request words, tracks enable and power-down, issues commands
// depends on klfc_pkg and klfc_if

module klfc_front import klfc_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   klfc_req_if.sink  req,
   input  logic      q_full,
   output logic      q_push,
   output cmd_type   q_cmd
);

   logic strip_enabled_ff, strip_enabled_in;
   logic powered_down_ff, powered_down_in;
   logic accept;
   logic [7:0] led;

   assign req.ready = !q_full;
   assign accept    = req.valid && req.ready;
   assign led       = key_to_led(req.key_row, req.key_col);

   always_comb begin
      strip_enabled_in = strip_enabled_ff;
      powered_down_in  = powered_down_ff;
      q_push           = 1'b0;
      q_cmd.op         = CMD_CLEAR;
      q_cmd.led        = led[LED_IDX_W-1:0];
      q_cmd.supply     = 1'b0;
      q_cmd.stop_fade  = 1'b0;
      case (req.kind)
         KIND_KEY: begin
            q_cmd.op = CMD_KEY;
            q_push   = req.key_pressed && strip_enabled_ff && !powered_down_ff &&
                       (led != NO_LED);
         end
         KIND_TICK: begin
            // the back end drops it when no fade is running
            q_cmd.op = CMD_TICK;
            q_push   = 1'b1;
         end
         KIND_ENABLE: begin
            strip_enabled_in = req.enable_value;
            q_cmd.supply     = req.enable_value;
            q_cmd.stop_fade  = !req.enable_value;
            q_push           = 1'b1;
         end
         KIND_SLEEP: begin
            powered_down_in = 1'b1;
            q_cmd.stop_fade = 1'b1;
            q_push          = !powered_down_ff;
         end
         KIND_WAKE: begin
            powered_down_in = 1'b0;
            q_cmd.supply    = 1'b1;
            q_push          = powered_down_ff && strip_enabled_ff;
         end
         default: begin
            q_push = 1'b0;
         end
      endcase
      if (!accept) begin
         strip_enabled_in = strip_enabled_ff;
         powered_down_in  = powered_down_ff;
         q_push           = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strip_enabled_ff <= 1'b1;
         powered_down_ff  <= 1'b0;
      end else begin
         strip_enabled_ff <= strip_enabled_in;
         powered_down_ff  <= powered_down_in;
      end
   end

endmodule

// File: hw/rtl/klfc_queue.sv
// klfc_queue: two-entry command queue between front and back end
// depends on klfc_pkg

module klfc_queue import klfc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output logic    empty,
   output cmd_type head
);

   cmd_type    slot_ff [0:1];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign full    = (count_ff == 2'd2);
   assign empty   = (count_ff == 2'd0);
   assign head    = slot_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// File: hw/rtl/klfc_back.sv
// klfc_back: led store, fade update, theme registers and pixel refresh sweep
// depends on klfc_pkg and klfc_if

module klfc_back import klfc_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      q_empty,
   input  cmd_type   q_head,
   output logic      q_pop,
   klfc_csr_if.sink  csr,
   klfc_rsp_if.source rsp
);

   typedef enum logic {
      ST_IDLE,
      ST_SWEEP
   } state_type;

   state_type            state_ff;
   logic [7:0]           bright_ff [0:NUM_LEDS-1];
   logic                 active_ff [0:NUM_LEDS-1];
   logic                 fade_ff;
   logic                 supply_ff;
   logic [7:0]           red_ff, green_ff, blue_ff, step_ff;
   logic [LED_IDX_W-1:0] idx_ff;

   logic                 out_valid_ff;
   logic [4:0]           out_index_ff;
   logic [7:0]           out_red_ff, out_green_ff, out_blue_ff;
   logic                 out_last_ff, out_power_ff;

   logic [7:0]           tick_bright [0:NUM_LEDS-1];
   logic                 tick_active [0:NUM_LEDS-1];
   logic                 tick_any;
   logic                 load;
   logic [7:0]           pix_b;
   logic                 pix_last;

   assign csr.ready = 1'b1;
   assign q_pop     = (state_ff == ST_IDLE) && !q_empty;
   assign load      = (state_ff == ST_SWEEP) && (!out_valid_ff || rsp.ready);
   assign pix_b     = active_ff[idx_ff] ? bright_ff[idx_ff] : 8'd0;
   assign pix_last  = (idx_ff == LED_IDX_W'(NUM_LEDS - 1));

   assign rsp.valid      = out_valid_ff;
   assign rsp.led_index  = out_index_ff;
   assign rsp.red        = out_red_ff;
   assign rsp.green      = out_green_ff;
   assign rsp.blue       = out_blue_ff;
   assign rsp.last_pixel = out_last_ff;
   assign rsp.power_on   = out_power_ff;

   // one fade tick over every led at once
   always_comb begin
      tick_any = 1'b0;
      for (int i = 0; i < NUM_LEDS; i++) begin
         tick_bright[i] = bright_ff[i];
         tick_active[i] = active_ff[i];
         if (active_ff[i]) begin
            if (bright_ff[i] > step_ff) begin
               tick_bright[i] = bright_ff[i] - step_ff;
               tick_any       = 1'b1;
            end else begin
               tick_bright[i] = 8'd0;
               tick_active[i] = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fade_ff      <= 1'b0;
         supply_ff    <= 1'b1;
         red_ff       <= 8'd0;
         green_ff     <= 8'd255;
         blue_ff      <= 8'd0;
         step_ff      <= 8'd4;
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_LEDS; i++) begin
            bright_ff[i] <= 8'd0;
            active_ff[i] <= 1'b0;
         end
      end else begin
         if (csr.valid) begin
            case (csr.index)
               CSR_THEME_RED:   red_ff   <= csr.data;
               CSR_THEME_GREEN: green_ff <= csr.data;
               CSR_THEME_BLUE:  blue_ff  <= csr.data;
               CSR_FADE_STEP:   step_ff  <= csr.data;
               default:         red_ff   <= red_ff;
            endcase
         end
         if (load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            out_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               idx_ff <= '0;
               if (!q_empty) begin
                  case (q_head.op)
                     CMD_KEY: begin
                        bright_ff[q_head.led] <= FULL_BRIGHT;
                        active_ff[q_head.led] <= 1'b1;
                        fade_ff               <= 1'b1;
                        state_ff              <= ST_SWEEP;
                     end
                     CMD_TICK: begin
                        if (fade_ff) begin
                           bright_ff <= tick_bright;
                           active_ff <= tick_active;
                           fade_ff   <= tick_any;
                           state_ff  <= ST_SWEEP;
                        end
                     end
                     CMD_CLEAR: begin
                        for (int i = 0; i < NUM_LEDS; i++) begin
                           bright_ff[i] <= 8'd0;
                           active_ff[i] <= 1'b0;
                        end
                        supply_ff <= q_head.supply;
                        if (q_head.stop_fade) begin
                           fade_ff <= 1'b0;
                        end
                        state_ff <= ST_SWEEP;
                     end
                     default: begin
                        state_ff <= ST_IDLE;
                     end
                  endcase
               end
            end
            ST_SWEEP: begin
               if (load) begin
                  idx_ff <= idx_ff + LED_IDX_W'(1);
                  if (pix_last) begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
      if (load) begin
         out_index_ff <= 5'(idx_ff);
         out_red_ff   <= scale(red_ff, pix_b);
         out_green_ff <= scale(green_ff, pix_b);
         out_blue_ff  <= scale(blue_ff, pix_b);
         out_last_ff  <= pix_last;
         out_power_ff <= supply_ff;
      end
   end

endmodule

// File: hw/rtl/keypress_led_fade_controller.sv
// keypress_led_fade_controller: top level of the per-key led fade engine
// depends on klfc_pkg, klfc_if, klfc_front, klfc_queue, klfc_back
//
//   channel  dir  word                                               handshake
//   req_ch   in   kind, key_pressed, key_row, key_col, enable_value  valid/ready
//   rsp_ch   out  led_index, red, green, blue, last_pixel, power_on  valid/ready
//   csr_ch   in   index (0 red, 1 green, 2 blue, 3 fade step), data  valid/ready
//
// a request word that changes the picture gives 17 pixel words, one per cycle
// unless rsp stalls, after the back end takes its command; the sweep sets the rate
// requests are classified on arrival and wait in a two-entry command queue
// reset is synchronous; csr words are taken every cycle
// a stalled response holds the sweep, and the queue then fills and drops req ready

module keypress_led_fade_controller import klfc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   klfc_req_if.sink    req_ch,
   klfc_rsp_if.source  rsp_ch,
   klfc_csr_if.sink    csr_ch
);

   logic    q_push, q_full, q_pop, q_empty;
   cmd_type q_cmd, q_head;

   klfc_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req    (req_ch),
      .q_full (q_full),
      .q_push (q_push),
      .q_cmd  (q_cmd)
   );

   klfc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .empty    (q_empty),
      .head     (q_head)
   );

   klfc_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_empty (q_empty),
      .q_head  (q_head),
      .q_pop   (q_pop),
      .csr     (csr_ch),
      .rsp     (rsp_ch)
   );

endmodule
